FILE: sv/lpd_pkg.sv
package lpd_pkg;

    // request action codes
    localparam logic [1:0] ACT_KEY  = 2'd0;
    localparam logic [1:0] ACT_COEF = 2'd1;
    localparam logic [1:0] ACT_BODY = 2'd2;

    // configuration register indexes
    localparam logic CFG_DIMENSION = 1'b0;
    localparam logic CFG_MSG_SPACE = 1'b1;

    localparam logic [10:0] DIMENSION_RST = 11'd1024;
    localparam logic [16:0] MSG_SPACE_RST = 17'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [9:0]         position;
        logic               key_bit;
        logic signed [31:0] value;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] phase;
        logic signed [31:0] decoded;
    } t_out_rsp;

endpackage

FILE: sv/lpd_front.sv
module lpd_front #(
    parameter int MAX_DIMENSION = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lpd_pkg::t_in_req i_req,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [10:0]     i_dimension,
    output logic            o_push,
    output logic [31:0]     o_phase,
    input  logic            i_full
);
    import lpd_pkg::*;

    localparam int AW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;

    logic          r_key_mem [MAX_DIMENSION];
    logic          r_key;
    logic          r_s1_valid;
    logic [1:0]    r_s1_act;
    logic          r_s1_use;
    logic [31:0]   r_s1_val;
    logic [31:0]   r_sum;

    logic          acc;
    logic          pos_ok;
    logic          in_dim;
    logic          s1_go;
    logic [AW-1:0] addr;

    assign addr   = AW'(i_req.position);
    assign pos_ok = 32'(i_req.position) < 32'(MAX_DIMENSION);
    assign in_dim = {1'b0, i_req.position} < i_dimension;
    assign acc    = i_valid && o_ready;

    // a body waits in stage one while the queue is full
    assign s1_go   = r_s1_valid && ((r_s1_act != ACT_BODY) || !i_full);
    assign o_ready = !r_s1_valid || s1_go;
    assign o_push  = r_s1_valid && (r_s1_act == ACT_BODY) && !i_full;
    assign o_phase = r_s1_val - r_sum;

    // key store, read data registered on accept
    always_ff @(posedge i_clk) begin
        if (acc && (i_req.action == ACT_KEY) && pos_ok) begin
            r_key_mem[addr] <= i_req.key_bit;
        end
        if (acc) begin
            r_key <= r_key_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_act <= i_req.action;
            r_s1_use <= pos_ok && in_dim;
            r_s1_val <= $unsigned(i_req.value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_sum      <= '0;
        end else begin
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                case (r_s1_act)
                    ACT_COEF: begin
                        if (r_s1_use && r_key) begin
                            r_sum <= r_sum + r_s1_val;
                        end
                    end
                    ACT_BODY: begin
                        r_sum <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

FILE: sv/lpd_fifo.sv
module lpd_fifo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [31:0] i_data,
    output logic        o_full,
    input  logic        i_pop,
    output logic        o_valid,
    output logic [31:0] o_data
);
    logic [31:0] r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: sv/lpd_round.sv
module lpd_round (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  logic [31:0]       i_q_data,
    output logic              o_pop,
    input  logic [16:0]       i_msg_space,
    output lpd_pkg::t_out_rsp o_rsp,
    output logic              o_valid,
    input  logic              i_ready
);
    import lpd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IVL,
        ST_PREP,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_state;

    t_state      r_state;
    logic [31:0] r_ph;
    logic [31:0] r_dec;
    logic [62:0] r_ivl;      // floor(2^63 / m), interval is twice this
    logic        r_ivl_ok;
    logic [16:0] r_ivl_m;
    logic [16:0] r_rmd;
    logic [5:0]  r_cnt;
    logic [63:0] r_acc;
    logic [63:0] r_rem;
    logic [79:0] r_d;
    logic [4:0]  r_step;
    logic        r_out_valid;
    t_out_rsp    r_out;

    logic [17:0] ivl_t;
    logic        ivl_ge;
    logic        div_ge;
    logic [63:0] grid;

    assign o_pop   = (r_state == ST_IDLE) && i_q_valid;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // long division of 2^63 by m, one quotient bit a cycle
    assign ivl_t  = {r_rmd, (r_cnt == 6'd63)};
    assign ivl_ge = ivl_t >= {1'b0, i_msg_space};
    // remainder against the interval shifted left, 17 quotient bits
    assign div_ge = {16'b0, r_rem} >= r_d;
    assign grid   = r_acc - r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ivl_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // in ST_DONE the result register is refilled below instead
            if (r_out_valid && i_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_ph <= i_q_data;
                        if (i_msg_space <= 17'd1) begin
                            r_dec   <= '0;
                            r_state <= ST_DONE;
                        end else if (r_ivl_ok && (r_ivl_m == i_msg_space)) begin
                            r_state <= ST_PREP;
                        end else begin
                            r_rmd   <= '0;
                            r_cnt   <= 6'd63;
                            r_state <= ST_IVL;
                        end
                    end
                end
                ST_IVL: begin
                    r_rmd <= ivl_ge ? 17'(ivl_t - {1'b0, i_msg_space}) : ivl_t[16:0];
                    r_ivl <= {r_ivl[61:0], ivl_ge};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_ivl_ok <= 1'b1;
                        r_ivl_m  <= i_msg_space;
                        r_state  <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    // phase * 2^32 plus half the interval, wrapping
                    r_acc   <= {r_ph, 32'b0} + {1'b0, r_ivl};
                    r_rem   <= {r_ph, 32'b0} + {1'b0, r_ivl};
                    r_d     <= {r_ivl, 1'b0, 16'b0};
                    r_step  <= 5'd16;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_ge) begin
                        r_rem <= r_rem - r_d[63:0];
                    end
                    r_d    <= r_d >> 1;
                    r_step <= r_step - 5'd1;
                    if (r_step == 5'd0) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_dec   <= grid[63:32];
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out.phase   <= $signed(r_ph);
                        r_out.decoded <= $signed(r_dec);
                        r_out_valid   <= 1'b1;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sv/lwe_phase_decrypt.sv
// channel   direction  handshake            payload
// request   in         i_valid / o_ready    i_req  (action, position, key_bit, value)
// result    out        o_valid / i_ready    o_rsp  (phase, decoded)
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// key writes and mask coefficients are taken one per cycle unless a body waits
// in stage one on a full queue; each passes a registered key-store read and then
// the accumulate stage; a body leaves its phase in a two-entry queue
// the rounding unit takes the next body only when done, via a shift-subtract
// divider (64 steps for the interval when message_space is new, 17 for the grid)
// reset clears control state and the accumulator; the key store is not cleared
// a stalled result holds in the output register while requests keep flowing
// until the queue fills
module lwe_phase_decrypt #(
    parameter int MAX_DIMENSION = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpd_pkg::t_in_req  i_req,
    input  logic              i_valid,
    output logic              o_ready,
    output lpd_pkg::t_out_rsp o_rsp,
    output logic              o_valid,
    input  logic              i_ready,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [16:0]       i_cfg_data
);
    import lpd_pkg::*;

    logic [10:0] r_dimension;
    logic [16:0] r_msg_space;

    logic        push;
    logic [31:0] push_phase;
    logic        q_full;
    logic        q_valid;
    logic [31:0] q_data;
    logic        pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimension <= DIMENSION_RST;
            r_msg_space <= MSG_SPACE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIMENSION: r_dimension <= i_cfg_data[10:0];
                CFG_MSG_SPACE: r_msg_space <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: accept, key store, masked accumulation
    lpd_front #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_dimension(r_dimension),
        .o_push     (push),
        .o_phase    (push_phase),
        .i_full     (q_full)
    );

    // phase queue between front and rounding
    lpd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_phase),
        .o_full (q_full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_data (q_data)
    );

    // back: rounding to the message grid and result register
    lpd_round u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_data),
        .o_pop      (pop),
        .i_msg_space(r_msg_space),
        .o_rsp      (o_rsp),
        .o_valid    (o_valid),
        .i_ready    (i_ready)
    );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import lpd_pkg::*;

    // action 3 has no meaning to the block and must leave it untouched
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam int MAX_DIM       = 1024;
    // enough for a body right after a message_space change plus the coefficient pipe
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int ITEMS_PER_MODE = 140;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    t_in_req     i_req      = '0;
    logic        i_valid    = 1'b0;
    logic        o_ready;
    t_out_rsp    o_rsp;
    logic        o_valid;
    logic        i_ready    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = CFG_DIMENSION;
    logic [16:0] i_cfg_data = '0;

    lwe_phase_decrypt #(
        .MAX_DIMENSION(MAX_DIM)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .o_rsp      (o_rsp),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the decryptor: key bits, running masked sum, live settings
    logic        key_mirror [MAX_DIM];
    bit          key_known  [MAX_DIM];
    int          known_pos_q [$];
    logic [31:0] mask_acc;
    logic [10:0] cur_dimension;
    logic [16:0] cur_msg_space;

    // phase/decoded pairs still owed by the block, oldest first
    t_out_rsp    phase_expect_q [$];
    t_out_rsp    rsp_head;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int sent_items   = 0;
    int fail_cnt     = 0;
    int cycle_cnt    = 0;

    initial forever #5 i_clk = ~i_clk;

    // -------------------------------------------------------------------------
    // prediction
    // -------------------------------------------------------------------------

    // round a torus phase to the nearest point of the message grid, ties upward;
    // the grid spacing is twice floor(2^63 / msg_space) on a 64-bit scale
    function automatic logic [31:0] nearest_grid_point(input logic [31:0] ph,
                                                       input logic [16:0] msg_space);
        logic [63:0] span;
        logic [63:0] acc;
        if (msg_space <= 17'd1) return '0;
        span = ((64'd1 << 63) / {47'd0, msg_space}) * 64'd2;
        acc  = {ph, 32'd0} + (span >> 1);
        acc  = acc - (acc % span);
        return acc[63:32];
    endfunction

    // advance the shadow by one accepted request; a body owes one result
    function automatic void predict_decrypt(input t_in_req req);
        t_out_rsp rsp;
        case (req.action)
            ACT_KEY: begin
                key_mirror[req.position] = req.key_bit;
                if (!key_known[req.position]) begin
                    key_known[req.position] = 1'b1;
                    known_pos_q.push_back(int'(req.position));
                end
            end
            ACT_COEF: begin
                // only in-dimension coefficients under a set key bit count
                if (req.position < cur_dimension && key_mirror[req.position] === 1'b1)
                    mask_acc = mask_acc + req.value;
            end
            ACT_BODY: begin
                rsp.phase   = req.value - mask_acc;
                rsp.decoded = nearest_grid_point(rsp.phase, cur_msg_space);
                mask_acc    = '0;
                phase_expect_q.push_back(rsp);
            end
            default: ;
        endcase
    endfunction

    // -------------------------------------------------------------------------
    // stimulus helpers
    // -------------------------------------------------------------------------

    function automatic t_in_req mk_req(input logic [1:0] act, input logic [9:0] pos,
                                       input logic kbit, input logic [31:0] val);
        t_in_req req;
        req.action   = act;
        req.position = pos;
        req.key_bit  = kbit;
        req.value    = val;
        return req;
    endfunction

    // coefficients, bodies and no-ops only touch key entries already written
    function automatic logic [9:0] pick_known_pos();
        return 10'(known_pos_q[$urandom_range(known_pos_q.size() - 1)]);
    endfunction

    // torus value with a bias toward the wrap points
    function automatic logic [31:0] rand_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // half the bodies land within three units of a grid point
    function automatic logic [31:0] body_value();
        logic [31:0] target;
        if ($urandom_range(1)) return $urandom;
        target = nearest_grid_point($urandom, cur_msg_space) + $urandom_range(6) - 3;
        return target + mask_acc;
    endfunction

    // one request over valid/ready; valid stays up between back-to-back requests
    task automatic send_request(input t_in_req req);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_decrypt(req);
        sent_items++;
    endtask

    // hold off the sender until every owed result has been taken
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (phase_expect_q.size() != 0);
    endtask

    // settings change only with the block idle; coefficients may still be in
    // flight after the last result, hence the settle time
    task automatic set_config(input logic [10:0] dim, input logic [16:0] msg_space);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DIMENSION;
        i_cfg_data <= {6'd0, dim};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MSG_SPACE;
        i_cfg_data <= msg_space;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_dimension = dim;
        cur_msg_space = msg_space;
    endtask

    task automatic random_config();
        logic [10:0] dim;
        logic [16:0] msg_space;
        case ($urandom_range(4))
            0:       dim = 11'(MAX_DIM);
            1:       dim = 11'($urandom_range(16, 1));
            default: dim = 11'($urandom_range(MAX_DIM, 1));
        endcase
        case ($urandom_range(4))
            0:       msg_space = 17'd2;
            1:       msg_space = 17'd65536;
            2:       msg_space = 17'd1 << $urandom_range(16, 1);
            default: msg_space = 17'($urandom_range(65536, 2));
        endcase
        set_config(dim, msg_space);
    endtask

    // one ciphertext: a run of coefficients with some key updates and no-ops
    // mixed in, closed by its body
    task automatic run_lwe_sample(input int n_coef);
        int k;
        for (k = 0; k < n_coef; k++) begin
            case ($urandom_range(9))
                0: send_request(mk_req(ACT_KEY, 10'($urandom_range(MAX_DIM - 1)),
                                       1'($urandom_range(1)), $urandom));
                1: send_request(mk_req(ACT_NONE, pick_known_pos(),
                                       1'($urandom_range(1)), $urandom));
                default: send_request(mk_req(ACT_COEF, pick_known_pos(),
                                             1'($urandom_range(1)), rand_value()));
            endcase
        end
        send_request(mk_req(ACT_BODY, pick_known_pos(), 1'($urandom_range(1)),
                            body_value()));
        // now and then let the result side catch up completely
        if ($urandom_range(15) == 0) drain_results();
    endtask

    // -------------------------------------------------------------------------
    // tests
    // -------------------------------------------------------------------------

    // reset settings (full dimension, two messages), every action, field extremes
    task automatic test_directed_items();
        send_request(mk_req(ACT_KEY,  10'd0,     1'b1, 32'h0000_0000));
        send_request(mk_req(ACT_KEY,  10'd1023,  1'b1, 32'hFFFF_FFFF));
        send_request(mk_req(ACT_KEY,  10'd1,     1'b0, 32'h5555_5555));
        send_request(mk_req(ACT_KEY,  10'h2AA,   1'b1, 32'hAAAA_AAAA));
        send_request(mk_req(ACT_KEY,  10'h155,   1'b0, 32'h0000_0000));
        // largest positive plus one wraps the masked sum to the negative end
        send_request(mk_req(ACT_COEF, 10'd0,     1'b0, 32'h7FFF_FFFF));
        send_request(mk_req(ACT_COEF, 10'd1023,  1'b1, 32'h0000_0001));
        // key bit clear: coefficient drops out
        send_request(mk_req(ACT_COEF, 10'd1,     1'b1, 32'h1234_5678));
        // no-op carrying a key bit must not write the key
        send_request(mk_req(ACT_NONE, 10'h2AA,   1'b1, 32'hFFFF_FFFF));
        send_request(mk_req(ACT_BODY, 10'd0,     1'b0, 32'h8000_0000));
        // empty samples: exact tie, just below it, and minus one
        send_request(mk_req(ACT_BODY, 10'd1023,  1'b1, 32'h4000_0000));
        send_request(mk_req(ACT_BODY, 10'h2AA,   1'b0, 32'h3FFF_FFFF));
        send_request(mk_req(ACT_BODY, 10'h155,   1'b1, 32'hFFFF_FFFF));
        send_request(mk_req(ACT_COEF, 10'h2AA,   1'b0, 32'h8000_0000));
        send_request(mk_req(ACT_COEF, 10'h155,   1'b1, 32'hFFFF_FFFF));
        // rewrite a key bit, then the same coefficient counts
        send_request(mk_req(ACT_KEY,  10'h155,   1'b1, 32'h0F0F_0F0F));
        send_request(mk_req(ACT_COEF, 10'h155,   1'b0, 32'hFFFF_FFFF));
        send_request(mk_req(ACT_BODY, 10'd0,     1'b1, 32'h7FFF_FFFF));
        send_request(mk_req(ACT_NONE, 10'h155,   1'b0, 32'h0000_0000));
        // tie on the far side rounds up through the wrap to zero
        send_request(mk_req(ACT_BODY, 10'd1,     1'b0, 32'hC000_0000));
    endtask

    // dimension zero, one, past the store, full and two others; message space zero,
    // one, top of the register, the largest legal one and two small odd ones; coefficients at the dimension edge
    task automatic test_config_corners();
        logic [10:0] dim;
        logic [16:0] msg_space;
        int          s;
        int          n;
        for (s = 0; s < 6; s++) begin
            case (s)
                0:       begin dim = 11'd0;    msg_space = 17'd0;     end
                1:       begin dim = 11'd1;    msg_space = 17'd1;     end
                2:       begin dim = 11'd2047; msg_space = 17'h1FFFF; end
                3:       begin dim = 11'd1024; msg_space = 17'd65536; end
                4:       begin dim = 11'd513;  msg_space = 17'd3;     end
                default: begin dim = 11'd5;    msg_space = 17'd7;     end
            endcase
            set_config(dim, msg_space);
            if (dim != 0 && dim <= MAX_DIM)
                send_request(mk_req(ACT_KEY, 10'(dim - 11'd1), 1'b1, $urandom));
            if (dim < MAX_DIM)
                send_request(mk_req(ACT_KEY, 10'(dim), 1'b1, $urandom));
            for (n = 0; n < 3; n++) begin
                if (dim != 0 && dim <= MAX_DIM)
                    send_request(mk_req(ACT_COEF, 10'(dim - 11'd1), 1'b0, rand_value()));
                if (dim < MAX_DIM)
                    send_request(mk_req(ACT_COEF, 10'(dim), 1'b0, rand_value()));
                send_request(mk_req(ACT_COEF, 10'd1023, 1'b1, rand_value()));
                run_lwe_sample(2);
            end
        end
    endtask

    // back-to-back bodies against a slow receiver fill the result queue
    task automatic test_result_backpressure();
        int k;
        src_idle_pct = 0;
        snk_idle_pct = 79;
        set_config(11'd1024, 17'd16);
        for (k = 0; k < 12; k++)
            send_request(mk_req(ACT_BODY, pick_known_pos(), 1'($urandom_range(1)),
                                $urandom));
        drain_results();
        for (k = 0; k < 6; k++) run_lwe_sample(1);
    endtask

    // random ciphertexts under random settings, through the three idle mixes
    task automatic test_random_samples();
        int k;
        int mode;
        int goal;
        int len;
        src_idle_pct = 23;
        snk_idle_pct = 79;
        // key load: a dense low block plus scattered entries
        for (k = 0; k < 48; k++)
            send_request(mk_req(ACT_KEY, 10'(k), 1'($urandom_range(1)), $urandom));
        for (k = 0; k < 16; k++)
            send_request(mk_req(ACT_KEY, 10'($urandom_range(MAX_DIM - 1)),
                                1'($urandom_range(1)), $urandom));
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0:       begin src_idle_pct = 23; snk_idle_pct = 79; end
                1:       begin src_idle_pct = 79; snk_idle_pct = 23; end
                default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            endcase
            random_config();
            goal = sent_items + ITEMS_PER_MODE;
            while (sent_items < goal) begin
                if ($urandom_range(29) == 0) random_config();
                case ($urandom_range(9))
                    0:       len = 0;
                    1:       len = $urandom_range(48, 20);
                    default: len = $urandom_range(8, 1);
                endcase
                run_lwe_sample(len);
            end
        end
    endtask

    // -------------------------------------------------------------------------
    // result side
    // -------------------------------------------------------------------------

    // receiver readiness, redrawn every cycle
    always @(posedge i_clk) i_ready <= ($urandom_range(99) >= snk_idle_pct);

    // each taken result against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (phase_expect_q.size() == 0) begin
                $error("result with nothing owed: phase %h decoded %h",
                       o_rsp.phase, o_rsp.decoded);
                fail_cnt++;
            end else begin
                rsp_head = phase_expect_q.pop_front();
                if (o_rsp.phase !== rsp_head.phase) begin
                    $error("phase: expected %h, actual %h", rsp_head.phase, o_rsp.phase);
                    fail_cnt++;
                end
                if (o_rsp.decoded !== rsp_head.decoded) begin
                    $error("decoded: expected %h, actual %h", rsp_head.decoded,
                           o_rsp.decoded);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("** lwe_phase_decrypt: FAILED **");
        $finish;
    end

    // -------------------------------------------------------------------------
    // sequence
    // -------------------------------------------------------------------------

    initial begin
        mask_acc      = '0;
        cur_dimension = DIMENSION_RST;
        cur_msg_space = MSG_SPACE_RST;
        src_idle_pct  = 23;
        snk_idle_pct  = 79;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_items();
        test_config_corners();
        test_result_backpressure();
        test_random_samples();

        // everything owed must arrive, and nothing more after it
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && phase_expect_q.size() == 0) begin
            $display("** lwe_phase_decrypt: PASSED **");
        end else begin
            $display("** lwe_phase_decrypt: FAILED **");
        end
        $finish;
    end

endmodule
